// ----- src/htfd_pkg.sv -----
// Types, constants and the CRC-8 step shared by the frame decoder modules.
`default_nettype none

package htfd_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [2:0]  FRAME_LAST  = 3'd6;
  localparam logic [2:0]  DATA_LAST   = 3'd5;
  localparam logic [9:0]  HUM_SCALE   = 10'd1000;
  localparam logic [10:0] TEMP_SCALE  = 11'd2000;
  localparam logic [11:0] TEMP_OFFSET = 12'd500;
  localparam int          DATA_BYTES  = 5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [9:0]         humidity_tenths;
    logic signed [11:0] temperature_tenths;
    logic               crc_ok;
    logic [7:0]         computed_crc;
  } out_t;

  typedef struct packed {
    logic [19:0] hum_raw;
    logic [19:0] temp_raw;
    logic        crc_ok;
    logic [7:0]  crc_six;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/htfd_front.sv -----
// Byte intake: frame position, running CRC, data byte capture and frame record hand-off.
`default_nettype none

module htfd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire htfd_pkg::in_t   in_data_i,
  input  wire htfd_pkg::qstat_t q_stat_i,
  output logic                 push_o,
  output htfd_pkg::frame_t     push_data_o
);

  logic [2:0] byte_count_q, byte_count_d;
  logic [7:0] running_crc_q, running_crc_d;
  logic [7:0] crc_six_q, crc_six_d;
  logic [7:0] data_q [htfd_pkg::DATA_BYTES];

  logic       accept;
  logic [2:0] idx;
  logic [7:0] crc_base;
  logic [7:0] crc_new;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    idx = byte_count_q;
    if (in_data_i.frame_start || (byte_count_q > htfd_pkg::FRAME_LAST)) begin
      idx = 3'd0;
    end
    crc_base = (idx == 3'd0) ? htfd_pkg::CRC_INIT : running_crc_q;
    crc_new  = htfd_pkg::crc8_update(crc_base, in_data_i.rx_byte);

    byte_count_d  = byte_count_q;
    running_crc_d = running_crc_q;
    crc_six_d     = crc_six_q;
    push_o        = 1'b0;
    if (accept) begin
      if (idx == htfd_pkg::DATA_LAST) begin
        crc_six_d = crc_new;
      end
      if (idx < htfd_pkg::FRAME_LAST) begin
        byte_count_d  = idx + 3'd1;
        running_crc_d = crc_new;
      end else begin
        byte_count_d  = 3'd0;
        running_crc_d = htfd_pkg::CRC_INIT;
        push_o        = 1'b1;
      end
    end

    push_data_o.hum_raw  = {data_q[0], data_q[1], data_q[2][7:4]};
    push_data_o.temp_raw = {data_q[2][3:0], data_q[3], data_q[4]};
    push_data_o.crc_ok   = (crc_new == 8'h00);
    push_data_o.crc_six  = crc_six_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= 3'd0;
      running_crc_q <= htfd_pkg::CRC_INIT;
      crc_six_q     <= 8'h00;
    end else begin
      byte_count_q  <= byte_count_d;
      running_crc_q <= running_crc_d;
      crc_six_q     <= crc_six_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (idx inside {[3'd1:htfd_pkg::DATA_LAST]})) begin
      data_q[idx - 3'd1] <= in_data_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

// ----- src/htfd_queue.sv -----
// Short queue of completed frame records between intake and scaling.
`default_nettype none

module htfd_queue #(
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire htfd_pkg::frame_t push_data_i,
  input  wire logic             pop_i,
  output htfd_pkg::frame_t      head_o,
  output htfd_pkg::qstat_t      stat_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  htfd_pkg::frame_t entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/htfd_back.sv -----
// Scaling of a frame record to tenths and the output register.
`default_nettype none

module htfd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire htfd_pkg::qstat_t q_stat_i,
  input  wire htfd_pkg::frame_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output htfd_pkg::out_t        out_data_o
);

  logic           out_valid_q, out_valid_d;
  htfd_pkg::out_t out_data_q, out_data_d;
  logic [29:0]    hum_prod;
  logic [30:0]    temp_prod;
  logic [11:0]    temp_val;

  assign pop_o     = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign hum_prod  = 30'(head_i.hum_raw) * 30'(htfd_pkg::HUM_SCALE);
  assign temp_prod = 31'(head_i.temp_raw) * 31'(htfd_pkg::TEMP_SCALE);
  assign temp_val  = {1'b0, temp_prod[30:20]} - htfd_pkg::TEMP_OFFSET;

  always_comb begin
    out_data_d.humidity_tenths    = head_i.crc_ok ? hum_prod[29:20] : 10'd0;
    out_data_d.temperature_tenths = head_i.crc_ok ? $signed(temp_val) : 12'sd0;
    out_data_d.crc_ok             = head_i.crc_ok;
    out_data_d.computed_crc       = head_i.crc_six;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- src/humidity_temp_frame_decoder_unit.sv -----
// Top level of the humidity and temperature sensor reply frame decoder.
//
// The input channel carries one byte of a seven-byte sensor reply per beat:
// status, five data bytes and the CRC, with frame_start marking a status byte.
// A beat is taken on any cycle where in_valid_i is high and in_stall_o low;
// one byte per cycle is sustained while in_stall_o is low (byte-wide CRC step).
// After the seventh byte a frame record enters a queue of QueueDepth entries.
// The back end scales it with one multiply per value into the output register;
// a result is registered in the queue and then in the output register after
// its CRC byte is taken.
// The output channel gives one beat per frame: humidity and temperature in
// tenths, the CRC verdict and the CRC over the first six bytes.
// While out_stall_i is high the result is held; frames keep being decoded and
// queued, and in_stall_o is high for every byte while the queue is full.
// Reset clears the byte position, restarts the CRC at 0xFF and empties the
// queue and output register; the decoder accepts bytes straight after reset.
`default_nettype none

module humidity_temp_frame_decoder_unit #(
  parameter int QueueDepth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire htfd_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output htfd_pkg::out_t      out_data_o
);

  htfd_pkg::qstat_t q_stat;
  htfd_pkg::frame_t push_data;
  htfd_pkg::frame_t head;
  logic             push;
  logic             pop;

  htfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  htfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  htfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- src/htfd_checker.sv -----
// Port-level checks of the frame decoder and their binding to the top level.
`default_nettype none

module htfd_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire htfd_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire htfd_pkg::out_t out_data_o
);

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> (!out_valid_o && !in_stall_o))
    else $error("outputs active during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.crc_ok) |->
      (out_data_o.humidity_tenths == 10'd0 && out_data_o.temperature_tenths == 12'sd0))
    else $error("non-zero values on CRC failure");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.crc_ok) |->
      (out_data_o.humidity_tenths <= 10'd999 &&
       $signed(out_data_o.temperature_tenths) >= -12'sd500 &&
       $signed(out_data_o.temperature_tenths) <= 12'sd1499))
    else $error("scaled value out of range");

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_htfd_checker (.*);

`default_nettype wire

// ----- tb/htfd_tb_pkg.sv -----
`timescale 1ns / 1ps
// Expected-result store and CRC helper for the sensor frame decoder testbench.
package htfd_tb_pkg;
  import htfd_pkg::*;

  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  class frame_scoreboard;
    logic [2:0] next_pos;
    logic [7:0] crc_acc;
    logic [7:0] crc_six;
    logic [7:0] frame_data [DATA_BYTES];
    out_t       expected_results [$];
    int         fail_count;

    function new();
      next_pos   = '0;
      crc_acc    = CRC_INIT;
      crc_six    = '0;
      fail_count = 0;
      foreach (frame_data[i]) frame_data[i] = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_byte(in_t beat);
      logic [2:0]  slot;
      logic [19:0] hum_raw;
      logic [19:0] temp_raw;
      logic [63:0] hum_wide;
      logic [63:0] temp_wide;
      out_t        res;
      slot = (beat.frame_start || next_pos > FRAME_LAST) ? 3'd0 : next_pos;
      if (slot == 3'd0) crc_acc = CRC_INIT;
      crc_acc = crc8_step(crc_acc, beat.rx_byte);
      if (slot >= 3'd1 && slot <= DATA_LAST) frame_data[slot - 3'd1] = beat.rx_byte;
      if (slot == DATA_LAST) crc_six = crc_acc;
      if (slot < FRAME_LAST) begin
        next_pos = slot + 3'd1;
        return;
      end
      res              = '0;
      res.crc_ok       = (crc_acc == 8'h00);
      res.computed_crc = crc_six;
      if (res.crc_ok) begin
        hum_raw   = {frame_data[0], frame_data[1], frame_data[2][7:4]};
        temp_raw  = {frame_data[2][3:0], frame_data[3], frame_data[4]};
        hum_wide  = (64'(hum_raw) * 64'(HUM_SCALE)) >> 20;
        temp_wide = (64'(temp_raw) * 64'(TEMP_SCALE)) >> 20;
        res.humidity_tenths    = hum_wide[9:0];
        res.temperature_tenths = temp_wide[11:0] - TEMP_OFFSET;
      end
      expected_results.push_back(res);
      next_pos = '0;
      crc_acc  = CRC_INIT;
    endfunction

    function void flag_mismatch(string field, longint want, longint got);
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with none expected: actual %h", $time, got);
        fail_count++;
        return;
      end
      want = expected_results.pop_front();
      if (got.humidity_tenths !== want.humidity_tenths)
        flag_mismatch("humidity_tenths", want.humidity_tenths, got.humidity_tenths);
      if (got.temperature_tenths !== want.temperature_tenths)
        flag_mismatch("temperature_tenths", want.temperature_tenths, got.temperature_tenths);
      if (got.crc_ok !== want.crc_ok)
        flag_mismatch("crc_ok", want.crc_ok, got.crc_ok);
      if (got.computed_crc !== want.computed_crc)
        flag_mismatch("computed_crc", want.computed_crc, got.computed_crc);
    endfunction
  endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top-level testbench of the humidity and temperature frame decoder.
module tb;
  import htfd_pkg::*;
  import htfd_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk         = 1'b0;
  logic rst_n;
  logic in_valid    = 1'b0;
  logic in_stall;
  in_t  in_data     = '0;
  logic out_valid;
  logic out_stall   = 1'b0;
  out_t out_data;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_cycles  = 0;
  int bytes_sent   = 0;
  int cycle_count  = 0;

  frame_scoreboard sb = new();

  humidity_temp_frame_decoder_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic send_byte(input in_t beat);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    sb.note_byte(beat);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] status, input logic [39:0] payload,
                            input bit flagged, input bit corrupt);
    logic [7:0] acc;
    logic [7:0] check;
    in_t        beat;
    acc = crc8_step(CRC_INIT, status);
    for (int i = 4; i >= 0; i--) acc = crc8_step(acc, payload[i*8 +: 8]);
    check = corrupt ? acc ^ 8'($urandom_range(1, 255)) : acc;
    beat.rx_byte     = status;
    beat.frame_start = flagged;
    send_byte(beat);
    beat.frame_start = 1'b0;
    for (int i = 4; i >= 0; i--) begin
      beat.rx_byte = payload[i*8 +: 8];
      send_byte(beat);
    end
    beat.rx_byte = check;
    send_byte(beat);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int   first;
    int   pick;
    int   len;
    in_t  beat;
    first = bytes_sent;
    while (bytes_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(8'($urandom), 40'({$urandom, $urandom}), $urandom_range(9) < 8, 1'b0);
      end else if (pick < 82) begin
        send_frame(8'($urandom), 40'({$urandom, $urandom}), $urandom_range(9) < 8, 1'b1);
      end else if (pick < 92) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          beat.rx_byte     = 8'($urandom);
          beat.frame_start = (i == 0);
          send_byte(beat);
        end
      end else begin
        beat.rx_byte     = 8'($urandom);
        beat.frame_start = 1'($urandom_range(1));
        send_byte(beat);
      end
    end
  endtask

  initial begin
    in_t beat;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Lowest readings, then highest readings on a frame that follows without a start flag.
    send_frame(8'h1C, 40'h00_0000_0000, 1'b1, 1'b0);
    send_frame(8'h00, 40'hFF_FFFF_FFFF, 1'b0, 1'b0);
    // A cut-off frame is dropped when a start flag arrives; the new frame has a bad CRC.
    beat.rx_byte     = 8'hFF;
    beat.frame_start = 1'b1;
    send_byte(beat);
    beat.rx_byte     = 8'h00;
    beat.frame_start = 1'b0;
    send_byte(beat);
    send_frame(8'h98, 40'h80_0880_0800, 1'b1, 1'b1);
    drain();

    run_random(360);
    drain();

    @(posedge clk);
    hold_cycles = 300;
    repeat (6) send_frame(8'($urandom), 40'({$urandom, $urandom}), 1'b1, 1'b0);
    drain();

    tx_idle_pct  = 63;
    rx_stall_pct = 0;
    run_random(350);
    drain();

    tx_idle_pct  = 0;
    rx_stall_pct = 63;
    run_random(350);
    drain();

    tx_idle_pct  = 34;
    rx_stall_pct = 34;
    run_random(350);
    drain();

    repeat (20) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
